// ===== design/lob_pkg.sv =====
// ----------------------------------------------------------------------------
// lob_pkg - shared types and constants of the order book engine
// field widths, event kinds, status codes and the controller/datapath links
// ----------------------------------------------------------------------------
`default_nettype none

package lob_pkg;

    localparam int KIND_W  = 2;
    localparam int ID_W    = 64;
    localparam int PRICE_W = 32;
    localparam int QTY_W   = 32;
    localparam int ST_W    = 2;

    // streaming payload widths, padded to whole bytes
    localparam int IN_W  = 200;
    localparam int OUT_W = 104;

    localparam logic [KIND_W-1:0] K_ADD     = 2'd0;
    localparam logic [KIND_W-1:0] K_CANCEL  = 2'd1;
    localparam logic [KIND_W-1:0] K_EXEC    = 2'd2;
    localparam logic [KIND_W-1:0] K_REPLACE = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd1;
    localparam logic [ST_W-1:0] ST_DUP     = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic            load;
        logic            oclr;
        logic            oscan;
        logic            lclr;
        logic            lscan;
        logic            key_ord;
        logic            drop;
        logic            ins;
        logic            out_load;
        logic [ST_W-1:0] st;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic              odone;
        logic              ldone;
        logic              ohit;
        logic              nhit;
        logic              ins_ok;
        logic              out_free;
        logic [KIND_W-1:0] kind;
    } t_stat;

endpackage

`default_nettype wire

// ===== design/lob_dp.sv =====
// ----------------------------------------------------------------------------
// lob_dp - order book datapath
// order and level tables, scan engines, update logic and result register
// ----------------------------------------------------------------------------
`default_nettype none

module lob_dp import lob_pkg::*; #(
    parameter int MAX_ORDERS = 256,
    parameter int MAX_LEVELS = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IN_W-1:0]  i_in_data,
    input  wire t_cmd             i_cmd,
    output t_stat                 o_stat,
    output logic                  o_tvalid,
    input  wire logic             i_tready,
    output logic [OUT_W-1:0]      o_tdata
);

    localparam int OIW = $clog2(MAX_ORDERS);
    localparam int LIW = $clog2(MAX_LEVELS);
    localparam int TW  = PRICE_W + OIW;
    localparam int CW  = $clog2(MAX_ORDERS + 1);

    // latched event
    logic [KIND_W-1:0]  r_kind;
    logic [ID_W-1:0]    r_id;
    logic [ID_W-1:0]    r_nkey;
    logic               r_side;
    logic [PRICE_W-1:0] r_price;
    logic [QTY_W-1:0]   r_qty;

    // order table
    logic [MAX_ORDERS-1:0] r_ov;
    logic [ID_W-1:0]       m_key   [MAX_ORDERS];
    logic                  m_oa    [MAX_ORDERS];
    logic [PRICE_W-1:0]    m_op    [MAX_ORDERS];
    logic [QTY_W-1:0]      m_rem   [MAX_ORDERS];
    logic [ID_W-1:0]       r_ok_q;
    logic                  r_oa_q;
    logic [PRICE_W-1:0]    r_op_q;
    logic [QTY_W-1:0]      r_or_q;

    // level table
    logic [MAX_LEVELS-1:0] r_lv;
    logic                  m_la    [MAX_LEVELS];
    logic [PRICE_W-1:0]    m_lp    [MAX_LEVELS];
    logic [TW-1:0]         m_lt    [MAX_LEVELS];
    logic [CW-1:0]         m_lc    [MAX_LEVELS];
    logic                  r_la_q;
    logic [PRICE_W-1:0]    r_lp_q;
    logic [TW-1:0]         r_lt_q;
    logic [CW-1:0]         r_lc_q;

    // order scan
    logic [OIW:0]   r_ocnt;
    logic           r_opv;
    logic [OIW-1:0] r_opi;
    logic           r_ohit, r_nhit, r_ofree;
    logic [OIW-1:0] r_oidx, r_fidx;

    // level scan
    logic [LIW:0]       r_lcnt;
    logic               r_lpv;
    logic [LIW-1:0]     r_lpi;
    logic               r_lhit, r_lfree;
    logic [LIW-1:0]     r_lidx, r_lfidx;
    logic               r_hb, r_ha;
    logic [PRICE_W-1:0] r_bb, r_ba;

    // result register
    logic               r_out_v;
    logic [OUT_W-1:0]   r_out_d;

    logic [OIW-1:0]     o_addr;
    logic [LIW-1:0]     l_addr;
    logic               key_ask;
    logic [PRICE_W-1:0] key_price;
    logic               full;
    logic [TW-1:0]      drop_amt;
    logic [TW-1:0]      drop_tot;
    logic [CW-1:0]      drop_cnt;
    logic               ins_ok;
    logic [LIW-1:0]     ins_lidx;
    logic [TW-1:0]      ins_tot;
    logic [CW-1:0]      ins_cnt;
    logic [PRICE_W-1:0] spread;

    assign o_addr    = i_cmd.oscan ? r_ocnt[OIW-1:0] : r_oidx;
    assign l_addr    = i_cmd.lscan ? r_lcnt[LIW-1:0] : r_lidx;
    assign key_ask   = i_cmd.key_ord ? r_oa_q : r_side;
    assign key_price = i_cmd.key_ord ? r_op_q : r_price;

    // cancel and replace always remove the whole order
    assign full     = (r_kind != K_EXEC) || (r_qty >= r_or_q);
    assign drop_amt = full ? TW'(r_or_q) : TW'(r_qty);
    assign drop_tot = (r_lt_q >= drop_amt) ? (r_lt_q - drop_amt) : '0;
    assign drop_cnt = (full && (r_lc_q != '0)) ? (r_lc_q - CW'(1)) : r_lc_q;

    assign ins_ok   = r_ofree && (r_lhit || r_lfree);
    assign ins_lidx = r_lhit ? r_lidx : r_lfidx;
    assign ins_tot  = r_lhit ? (r_lt_q + TW'(r_qty)) : TW'(r_qty);
    assign ins_cnt  = r_lhit ? (r_lc_q + CW'(1)) : CW'(1);

    assign spread = (r_hb && r_ha) ? (r_ba - r_bb) : '0;

    assign o_stat.odone    = (r_ocnt == (OIW+1)'(MAX_ORDERS)) && !r_opv;
    assign o_stat.ldone    = (r_lcnt == (LIW+1)'(MAX_LEVELS)) && !r_lpv;
    assign o_stat.ohit     = r_ohit;
    assign o_stat.nhit     = r_nhit;
    assign o_stat.ins_ok   = ins_ok;
    assign o_stat.out_free = !r_out_v || i_tready;
    assign o_stat.kind     = r_kind;

    assign o_tvalid = r_out_v;
    assign o_tdata  = r_out_d;

    // payload: event latch, table contents, registered reads, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_in_data[1:0];
            r_id    <= i_in_data[65:2];
            r_nkey  <= (i_in_data[1:0] == K_ADD) ? i_in_data[65:2] : i_in_data[129:66];
            r_side  <= i_in_data[130];
            r_price <= i_in_data[162:131];
            r_qty   <= i_in_data[194:163];
        end
        r_ok_q <= m_key[o_addr];
        r_oa_q <= m_oa[o_addr];
        r_op_q <= m_op[o_addr];
        r_or_q <= m_rem[o_addr];
        r_la_q <= m_la[l_addr];
        r_lp_q <= m_lp[l_addr];
        r_lt_q <= m_lt[l_addr];
        r_lc_q <= m_lc[l_addr];
        if (i_cmd.drop) begin
            if (!full) begin
                m_rem[r_oidx] <= r_or_q - r_qty;
            end
            if (r_lhit) begin
                m_lt[r_lidx] <= drop_tot;
                m_lc[r_lidx] <= drop_cnt;
            end
        end
        if (i_cmd.ins && ins_ok) begin
            m_key[r_fidx]  <= r_nkey;
            m_oa[r_fidx]   <= r_side;
            m_op[r_fidx]   <= r_price;
            m_rem[r_fidx]  <= r_qty;
            m_la[ins_lidx] <= r_side;
            m_lp[ins_lidx] <= r_price;
            m_lt[ins_lidx] <= ins_tot;
            m_lc[ins_lidx] <= ins_cnt;
        end
        if (i_cmd.out_load) begin
            r_out_d <= {4'd0, spread, r_ba, r_ha, r_bb, r_hb, i_cmd.st};
        end
    end

    // control: valid bits, scan counters and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= '0;
            r_lv    <= '0;
            r_ocnt  <= '0;
            r_opv   <= 1'b0;
            r_opi   <= '0;
            r_ohit  <= 1'b0;
            r_nhit  <= 1'b0;
            r_ofree <= 1'b0;
            r_oidx  <= '0;
            r_fidx  <= '0;
            r_lcnt  <= '0;
            r_lpv   <= 1'b0;
            r_lpi   <= '0;
            r_lhit  <= 1'b0;
            r_lfree <= 1'b0;
            r_lidx  <= '0;
            r_lfidx <= '0;
            r_hb    <= 1'b0;
            r_ha    <= 1'b0;
            r_bb    <= '0;
            r_ba    <= '0;
            r_out_v <= 1'b0;
        end else begin
            // order scan, one entry a cycle, read data arriving in the cycle after its address
            if (i_cmd.oclr) begin
                r_ocnt  <= '0;
                r_opv   <= 1'b0;
                r_ohit  <= 1'b0;
                r_nhit  <= 1'b0;
                r_ofree <= 1'b0;
                r_oidx  <= '0;
            end else if (i_cmd.oscan) begin
                if (r_ocnt != (OIW+1)'(MAX_ORDERS)) begin
                    r_ocnt <= r_ocnt + (OIW+1)'(1);
                    r_opv  <= 1'b1;
                    r_opi  <= r_ocnt[OIW-1:0];
                end else begin
                    r_opv <= 1'b0;
                end
                if (r_opv) begin
                    if (r_ov[r_opi] && (r_ok_q == r_id) && !r_ohit) begin
                        r_ohit <= 1'b1;
                        r_oidx <= r_opi;
                    end
                    if (r_ov[r_opi] && (r_ok_q == r_nkey)) begin
                        r_nhit <= 1'b1;
                    end
                    if (!r_ov[r_opi] && !r_ofree) begin
                        r_ofree <= 1'b1;
                        r_fidx  <= r_opi;
                    end
                end
            end

            // level scan: key match, first free entry and best prices
            if (i_cmd.lclr) begin
                r_lcnt  <= '0;
                r_lpv   <= 1'b0;
                r_lhit  <= 1'b0;
                r_lfree <= 1'b0;
                r_hb    <= 1'b0;
                r_ha    <= 1'b0;
                r_bb    <= '0;
                r_ba    <= '0;
            end else if (i_cmd.lscan) begin
                if (r_lcnt != (LIW+1)'(MAX_LEVELS)) begin
                    r_lcnt <= r_lcnt + (LIW+1)'(1);
                    r_lpv  <= 1'b1;
                    r_lpi  <= r_lcnt[LIW-1:0];
                end else begin
                    r_lpv <= 1'b0;
                end
                if (r_lpv) begin
                    if (r_lv[r_lpi]) begin
                        if ((r_la_q == key_ask) && (r_lp_q == key_price) && !r_lhit) begin
                            r_lhit <= 1'b1;
                            r_lidx <= r_lpi;
                        end
                        if (r_la_q) begin
                            if (!r_ha || (r_lp_q < r_ba)) begin
                                r_ha <= 1'b1;
                                r_ba <= r_lp_q;
                            end
                        end else begin
                            if (!r_hb || (r_lp_q > r_bb)) begin
                                r_hb <= 1'b1;
                                r_bb <= r_lp_q;
                            end
                        end
                    end else if (!r_lfree) begin
                        r_lfree <= 1'b1;
                        r_lfidx <= r_lpi;
                    end
                end
            end

            if (i_cmd.drop && full) begin
                r_ov[r_oidx] <= 1'b0;
                if (r_lhit && (drop_cnt == '0)) begin
                    r_lv[r_lidx] <= 1'b0;
                end
                // the freed slot may now be the lowest free one
                if (!r_ofree || (r_oidx < r_fidx)) begin
                    r_ofree <= 1'b1;
                    r_fidx  <= r_oidx;
                end
            end

            if (i_cmd.ins && ins_ok) begin
                r_ov[r_fidx]   <= 1'b1;
                r_lv[ins_lidx] <= 1'b1;
            end

            if (i_cmd.out_load) begin
                r_out_v <= 1'b1;
            end else if (i_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/lob_ctrl.sv =====
// ----------------------------------------------------------------------------
// lob_ctrl - order book controller
// sequences scans, updates and result hand-off for one event at a time
// ----------------------------------------------------------------------------
`default_nettype none

module lob_ctrl import lob_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_OSCAN, S_ORD_RD, S_DSCAN, S_DLRD, S_DUPD,
        S_ISCAN, S_ILRD, S_INS, S_BEST, S_DONE
    } t_state;

    t_state          r_state, n_state;
    logic [ST_W-1:0] r_st, n_st;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        o_cmd   = '0;
        o_cmd.st = r_st;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.oclr = 1'b1;
                    n_st       = ST_OK;
                    n_state    = S_OSCAN;
                end
            end
            S_OSCAN: begin
                o_cmd.oscan = 1'b1;
                if (i_stat.odone) begin
                    o_cmd.lclr = 1'b1;
                    if (i_stat.kind == K_ADD) begin
                        if (i_stat.nhit) begin
                            n_st    = ST_DUP;
                            n_state = S_BEST;
                        end else begin
                            n_state = S_ISCAN;
                        end
                    end else if (!i_stat.ohit) begin
                        n_st    = ST_UNKNOWN;
                        n_state = S_BEST;
                    end else if ((i_stat.kind == K_REPLACE) && i_stat.nhit) begin
                        n_st    = ST_DUP;
                        n_state = S_BEST;
                    end else begin
                        n_state = S_ORD_RD;
                    end
                end
            end
            S_ORD_RD: begin
                o_cmd.lclr    = 1'b1;
                o_cmd.key_ord = 1'b1;
                n_state       = S_DSCAN;
            end
            S_DSCAN: begin
                o_cmd.lscan   = 1'b1;
                o_cmd.key_ord = 1'b1;
                if (i_stat.ldone) begin
                    n_state = S_DLRD;
                end
            end
            S_DLRD: begin
                n_state = S_DUPD;
            end
            S_DUPD: begin
                o_cmd.drop = 1'b1;
                o_cmd.lclr = 1'b1;
                n_state = (i_stat.kind == K_REPLACE) ? S_ISCAN : S_BEST;
            end
            S_ISCAN: begin
                o_cmd.lscan = 1'b1;
                if (i_stat.ldone) begin
                    n_state = S_ILRD;
                end
            end
            S_ILRD: begin
                n_state = S_INS;
            end
            S_INS: begin
                o_cmd.ins  = 1'b1;
                o_cmd.lclr = 1'b1;
                n_st       = i_stat.ins_ok ? ST_OK : ST_FULL;
                n_state    = S_BEST;
            end
            S_BEST: begin
                o_cmd.lscan = 1'b1;
                if (i_stat.ldone) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= ST_OK;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

endmodule

`default_nettype wire

// ===== design/limit_order_book_engine.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_engine - order book with best bid, best ask and spread
// top level joining the event controller and the table datapath
// ----------------------------------------------------------------------------
// Each input item is one order event (add, cancel, execute or replace) and
// gives exactly one result item: a status and the best bid, best ask and
// spread of the book after the event. Orders live in a table of MAX_ORDERS
// entries and price levels in a table of MAX_LEVELS entries; both are
// memories with one read and one write port, searched one entry a cycle.
// An event takes one pass over the order table, up to two passes over the
// level table for the lookup and update (none for an unknown or duplicate
// id), plus a final pass over the level table for the best prices. A new
// item is taken only once the result of the last one is loaded, and the
// input is ready again in the cycle after that load. The result register
// lets the next item be taken while a result still waits; the load waits
// only while an earlier result is still held. No clearing pass is needed
// after reset: the valid bits of both tables are flip-flops.
`default_nettype none

module limit_order_book_engine import lob_pkg::*; #(
    parameter int MAX_ORDERS = 256,
    parameter int MAX_LEVELS = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    // kind[1:0], ord_id[65:2], new_id[129:66], side[130], price[162:131],
    // qty[194:163], zero pad above
    input  wire logic [IN_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    // status[1:0], bid_present[2], bid_price[34:3], ask_present[35],
    // ask_price[67:36], spread[99:68], zero pad above
    output logic [OUT_W-1:0]      o_m_tdata
);

    t_cmd  cmd;
    t_stat stat;

    // event sequencing
    lob_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // tables, scans and the result register
    lob_dp #(
        .MAX_ORDERS (MAX_ORDERS),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_data (i_s_tdata),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_tvalid  (o_m_tvalid),
        .i_tready  (i_m_tready),
        .o_tdata   (o_m_tdata)
    );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the limit order book engine
// drives order events over the input stream, predicts status and best prices
// ----------------------------------------------------------------------------
// A directed table covers the empty book, unknown ids, duplicates, zero
// quantity, partial and full executes, replaces and a crossed book. Fills of
// both tables follow, then random traffic over a small pool of ids and prices
// so that orders meet again and levels share orders. Every result item is
// checked field by field against its typed-in quote or the in-bench model.
`default_nettype none

module testbench;
    import lob_pkg::*;

    localparam int N_ORD  = 256;
    localparam int N_LVL  = 64;
    localparam int N_FREE = 40;
    localparam int WDOG   = 20000;

    // first member in the highest bits, so status lands in the lowest
    typedef struct packed {
        logic [PRICE_W-1:0] spread;
        logic [PRICE_W-1:0] ask_px;
        logic               ask_present;
        logic [PRICE_W-1:0] bid_px;
        logic               bid_present;
        logic [ST_W-1:0]    status;
    } t_quote;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [ID_W-1:0]    id;
        logic [ID_W-1:0]    nid;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        bit                 fixed;
        t_quote             want;
    } t_event;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    always #5 i_clk = ~i_clk;

    limit_order_book_engine i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    // book model
    bit                 bk_ord_v [N_ORD];
    logic [ID_W-1:0]    bk_ord_id[N_ORD];
    bit                 bk_ord_a [N_ORD];
    logic [PRICE_W-1:0] bk_ord_p [N_ORD];
    logic [QTY_W-1:0]   bk_ord_r [N_ORD];
    bit                 bk_lvl_v [N_LVL];
    bit                 bk_lvl_a [N_LVL];
    logic [PRICE_W-1:0] bk_lvl_p [N_LVL];
    logic [39:0]        bk_lvl_t [N_LVL];
    int                 bk_lvl_n [N_LVL];

    t_quote pending_quotes[$];
    int errors = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    function automatic int find_order(logic [ID_W-1:0] id);
        for (int i = 0; i < N_ORD; i++)
            if (bk_ord_v[i] && bk_ord_id[i] == id) return i;
        return -1;
    endfunction

    function automatic int find_level(bit a, logic [PRICE_W-1:0] p);
        for (int i = 0; i < N_LVL; i++)
            if (bk_lvl_v[i] && bk_lvl_a[i] == a && bk_lvl_p[i] == p) return i;
        return -1;
    endfunction

    function automatic void remove_order(int i);
        int l;
        l = find_level(bk_ord_a[i], bk_ord_p[i]);
        if (l >= 0) begin
            bk_lvl_t[l] = (bk_lvl_t[l] >= bk_ord_r[i]) ? bk_lvl_t[l] - bk_ord_r[i] : '0;
            if (bk_lvl_n[l] > 0) bk_lvl_n[l]--;
            if (bk_lvl_n[l] == 0) bk_lvl_v[l] = 0;
        end
        bk_ord_v[i] = 0;
    endfunction

    function automatic logic [ST_W-1:0] rest_order(logic [ID_W-1:0] id, bit a,
                                                   logic [PRICE_W-1:0] p,
                                                   logic [QTY_W-1:0] q);
        int slot;
        int l;
        slot = -1;
        if (find_order(id) >= 0) return ST_DUP;
        for (int i = 0; i < N_ORD; i++)
            if (!bk_ord_v[i]) begin slot = i; break; end
        l = find_level(a, p);
        if (l < 0) begin
            for (int i = 0; i < N_LVL; i++)
                if (!bk_lvl_v[i]) begin l = i; break; end
            if (slot < 0 || l < 0) return ST_FULL;
            bk_lvl_v[l] = 1; bk_lvl_a[l] = a; bk_lvl_p[l] = p;
            bk_lvl_t[l] = '0; bk_lvl_n[l] = 0;
        end
        if (slot < 0) return ST_FULL;
        bk_lvl_t[l] += q;
        bk_lvl_n[l]++;
        bk_ord_v[slot] = 1; bk_ord_id[slot] = id; bk_ord_a[slot] = a;
        bk_ord_p[slot] = p; bk_ord_r[slot] = q;
        return ST_OK;
    endfunction

    // applies one event to the book and returns the quote after it
    function automatic t_quote apply_event(t_event e);
        t_quote res;
        int i;
        int l;
        res = '0;
        case (e.kind)
            K_ADD: res.status = rest_order(e.id, e.side, e.price, e.qty);
            K_CANCEL: begin
                i = find_order(e.id);
                if (i < 0) res.status = ST_UNKNOWN;
                else begin remove_order(i); res.status = ST_OK; end
            end
            K_EXEC: begin
                i = find_order(e.id);
                if (i < 0) res.status = ST_UNKNOWN;
                else if (e.qty >= bk_ord_r[i]) begin
                    remove_order(i); res.status = ST_OK;
                end else begin
                    l = find_level(bk_ord_a[i], bk_ord_p[i]);
                    bk_ord_r[i] -= e.qty;
                    if (l >= 0) bk_lvl_t[l] = (bk_lvl_t[l] >= e.qty) ? bk_lvl_t[l] - e.qty : '0;
                    res.status = ST_OK;
                end
            end
            default: begin
                i = find_order(e.id);
                if (i < 0) res.status = ST_UNKNOWN;
                else if (find_order(e.nid) >= 0) res.status = ST_DUP;
                else begin
                    remove_order(i);
                    res.status = rest_order(e.nid, e.side, e.price, e.qty);
                end
            end
        endcase
        for (int k = 0; k < N_LVL; k++) begin
            if (!bk_lvl_v[k]) continue;
            if (bk_lvl_a[k]) begin
                if (!res.ask_present || bk_lvl_p[k] < res.ask_px) begin
                    res.ask_px = bk_lvl_p[k]; res.ask_present = 1;
                end
            end else if (!res.bid_present || bk_lvl_p[k] > res.bid_px) begin
                res.bid_px = bk_lvl_p[k]; res.bid_present = 1;
            end
        end
        if (res.bid_present && res.ask_present) res.spread = res.ask_px - res.bid_px;
        return res;
    endfunction

    function automatic t_event mk(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
                                  logic [ID_W-1:0] nid, bit s,
                                  logic [PRICE_W-1:0] p, logic [QTY_W-1:0] q);
        t_event e;
        e.kind = k; e.id = id; e.nid = nid; e.side = s; e.price = p; e.qty = q;
        e.fixed = 0; e.want = '0;
        return e;
    endfunction

    // directed row with a typed-in quote
    function automatic t_event mkq(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
                                   logic [ID_W-1:0] nid, bit s,
                                   logic [PRICE_W-1:0] p, logic [QTY_W-1:0] q,
                                   logic [ST_W-1:0] st, bit hb, logic [PRICE_W-1:0] bb,
                                   bit ha, logic [PRICE_W-1:0] ba,
                                   logic [PRICE_W-1:0] sp);
        t_event e;
        e = mk(k, id, nid, s, p, q);
        e.fixed = 1;
        e.want = '{status: st, bid_present: hb, bid_px: bb, ask_present: ha,
                   ask_px: ba, spread: sp};
        return e;
    endfunction

    task automatic send_event(t_event e);
        t_quote q;
        q = apply_event(e);
        if (e.fixed && q !== e.want)
            $display("%0t directed row disagrees with book model: %h vs %h",
                     $time, e.want, q);
        pending_quotes = {pending_quotes, (e.fixed ? e.want : q)};
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) @(posedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, e.qty, e.price, e.side, e.nid, e.id, e.kind};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver: random stalls, compare against the oldest quote
    always @(posedge i_clk) begin
        t_quote got;
        t_quote exp_q;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata[99:0];
            if (pending_quotes.size() == 0) begin
                $display("%0t unexpected result item %h", $time, got);
                errors++;
            end else begin
                exp_q = pending_quotes.pop_front();
                if (got.status !== exp_q.status) begin
                    $display("%0t status exp %0d got %0d", $time, exp_q.status, got.status);
                    errors++;
                end
                if (got.bid_present !== exp_q.bid_present || got.bid_px !== exp_q.bid_px) begin
                    $display("%0t bid exp %0b/%0d got %0b/%0d", $time, exp_q.bid_present,
                             exp_q.bid_px, got.bid_present, got.bid_px);
                    errors++;
                end
                if (got.ask_present !== exp_q.ask_present || got.ask_px !== exp_q.ask_px) begin
                    $display("%0t ask exp %0b/%0d got %0b/%0d", $time, exp_q.ask_present,
                             exp_q.ask_px, got.ask_present, got.ask_px);
                    errors++;
                end
                if (got.spread !== exp_q.spread) begin
                    $display("%0t spread exp %0d got %0d", $time, exp_q.spread, got.spread);
                    errors++;
                end
            end
        end
        m_tready <= !(stall_pct > 0 && $urandom_range(99, 0) < stall_pct);
    end

    // watchdog on cycles with no handshake on either side
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WDOG) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    logic [ID_W-1:0]    id_pool[16];
    logic [PRICE_W-1:0] px_pool[12];

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(9, 0) == 0) return {$urandom, $urandom};
        return id_pool[$urandom_range(15, 0)];
    endfunction

    function automatic logic [QTY_W-1:0] pick_qty();
        case ($urandom_range(5, 0))
            0: return '0;
            1: return '1;
            2: return $urandom;
            default: return $urandom_range(20, 1);
        endcase
    endfunction

    task automatic random_phase(int count, int ip, int sp);
        t_event e;
        logic [ID_W-1:0] nid;
        idle_pct = ip;
        stall_pct = sp;
        for (int n = 0; n < count; n++) begin
            nid = pick_id();
            e = mk(KIND_W'($urandom_range(3, 0)), pick_id(), nid, 1'($urandom_range(1, 0)),
                   $urandom_range(3, 0) == 0 ? $urandom : px_pool[$urandom_range(11, 0)],
                   pick_qty());
            send_event(e);
        end
    endtask

    // fills the order table past its size, then frees part of it again
    task automatic fill_orders();
        idle_pct = 0;
        stall_pct = 0;
        for (int n = 0; n < N_ORD + 2; n++)
            send_event(mk(K_ADD, 64'h1000 + n, '0, n[0], 32'd500 + n % 8, 32'd3));
        for (int n = 0; n < N_FREE; n++)
            send_event(mk(K_CANCEL, 64'h1000 + n, '0, 1'b0, '0, '0));
    endtask

    // more distinct prices than levels
    task automatic fill_levels();
        for (int n = 0; n < N_LVL + 3; n++)
            send_event(mk(K_ADD, 64'h2000 + n, '0, 1'b1, 32'd9000 + n, 32'd1));
        send_event(mk(K_REPLACE, 64'h2000, 64'h3000, 1'b0, 32'd1, 32'd1));
        for (int n = 0; n < N_LVL + 3; n++)
            send_event(mk(K_CANCEL, 64'h2000 + n, '0, 1'b0, '0, '0));
    endtask

    task automatic drain();
        while (pending_quotes.size() != 0) @(posedge i_clk);
    endtask

    t_event plan[$];

    function automatic void add_row(t_event e);
        plan = {plan, e};
    endfunction

    initial begin
        for (int k = 0; k < 16; k++) id_pool[k] = (k == 15) ? '1 : k;
        for (int k = 0; k < 12; k++) px_pool[k] = 32'd100 + 3 * k;
        px_pool[0] = '0;
        px_pool[11] = '1;
        for (int k = 0; k < N_ORD; k++) bk_ord_v[k] = 0;
        for (int k = 0; k < N_LVL; k++) bk_lvl_v[k] = 0;

        // kind id nid side price qty | status hb bb ha ba spread
        add_row(mkq(K_CANCEL, 64'd5, '0, 1'b0, '0, '0, ST_UNKNOWN, 0, 0, 0, 0, 0));
        add_row(mkq(K_EXEC, '1, '0, 1'b0, '0, '1, ST_UNKNOWN, 0, 0, 0, 0, 0));
        add_row(mkq(K_REPLACE, 64'd1, 64'd2, 1'b0, 32'd1, 32'd1,
                    ST_UNKNOWN, 0, 0, 0, 0, 0));
        add_row(mkq(K_ADD, 64'd1, '0, 1'b0, 32'd100, 32'd10, ST_OK, 1, 100, 0, 0, 0));
        add_row(mkq(K_ADD, 64'd1, '0, 1'b1, 32'd200, 32'd10, ST_DUP, 1, 100, 0, 0, 0));
        add_row(mkq(K_ADD, 64'd2, '0, 1'b1, 32'd150, 32'd5, ST_OK, 1, 100, 1, 150, 50));
        add_row(mkq(K_ADD, '1, '0, 1'b1, '1, '1, ST_OK, 1, 100, 1, 150, 50));
        add_row(mkq(K_ADD, 64'd0, '0, 1'b0, '0, '0, ST_OK, 1, 100, 1, 150, 50));
        add_row(mk(K_ADD, 64'd3, '0, 1'b0, 32'd100, 32'd7));
        add_row(mk(K_EXEC, 64'd3, '0, 1'b0, '0, 32'd3));
        add_row(mk(K_EXEC, 64'd3, '0, 1'b0, '0, 32'd4));
        add_row(mk(K_EXEC, 64'd1, '0, 1'b0, '0, '1));
        add_row(mkq(K_REPLACE, 64'd2, 64'd2, 1'b0, 32'd1, 32'd1,
                    ST_DUP, 1, 0, 1, 150, 150));
        add_row(mk(K_REPLACE, 64'd2, 64'd9, 1'b0, 32'd160, 32'd4));
        add_row(mk(K_CANCEL, 64'd9, '0, 1'b0, '0, '0));
        add_row(mk(K_ADD, 64'd10, '0, 1'b0, '1, 32'd1));
        add_row(mk(K_EXEC, 64'd0, '0, 1'b0, '0, '0));
        add_row(mk(K_CANCEL, '1, '0, 1'b0, '0, '0));
        add_row(mk(K_CANCEL, 64'd10, '0, 1'b0, '0, '0));
        add_row(mk(K_ADD, 64'h5555_5555_5555_5555, '0, 1'b1, 32'h5555_5555, 32'h5555_5555));
        add_row(mk(K_REPLACE, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0,
                   32'hAAAA_AAAA, 32'hAAAA_AAAA));
        add_row(mk(K_CANCEL, 64'hAAAA_AAAA_AAAA_AAAA, '0, 1'b0, '0, '0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) send_event(plan[k]);
        drain();                       // sender holds off until the book has caught up
        fill_levels();
        fill_orders();
        random_phase(20, 0, 0);
        random_phase(20, 60, 0);
        random_phase(20, 0, 60);
        random_phase(20, 25, 25);
        idle_pct = 0;
        stall_pct = 0;
        drain();
        repeat (N_ORD + 3 * N_LVL + 40) @(posedge i_clk);
        if (errors == 0 && pending_quotes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
